// ===== rtl/core/deadline_event_slot_table_defines.svh =====
// Assertion macros used by the checker of the slot table.
`ifndef DEADLINE_EVENT_SLOT_TABLE_DEFINES_SVH
`define DEADLINE_EVENT_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DEST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dest_pkg.sv =====
`timescale 1ns / 1ps
package dest_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DL_W        = 32;
    localparam int HDL_W       = 8;
    localparam int TAG_W       = 16;
    localparam int ENTRY_W     = DL_W + HDL_W + TAG_W;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_FULL      = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_BAD_ID    = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ONE  = 5'b00100,
        S_SEEK = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [30:0] delay_ms;
        logic [7:0]  slot_id;
        logic [7:0]  handler_id;
        logic [15:0] user_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_slot;
        logic [7:0]  out_handler;
        logic [15:0] out_tag;
        logic [31:0] earliest_deadline;
        logic        any_pending;
        logic        table_full;
        logic        last;
    } t_out_item;

    // result of the shared time compare unit
    typedef struct packed {
        logic             due;
        logic             better;
        logic [DL_W-1:0]  span;
    } t_cmp_res;

endpackage

// ===== rtl/core/dest_if.sv =====
`timescale 1ns / 1ps
interface dest_in_if;
    logic               valid;
    logic               ready;
    dest_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface dest_out_if;
    logic                valid;
    logic                ready;
    dest_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/dest_ram.sv =====
`timescale 1ns / 1ps
module dest_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dest_unit.sv =====
`timescale 1ns / 1ps
// Wrap-safe time compare: one subtract gives both the due test and the
// biased distance used to track the nearest deadline.
module dest_unit (
    input  logic [dest_pkg::DL_W-1:0] i_deadline,
    input  logic [dest_pkg::DL_W-1:0] i_now,
    input  logic [dest_pkg::DL_W-1:0] i_best_dist,
    input  logic                      i_have_best,
    output dest_pkg::t_cmp_res        o_res
);

    logic [dest_pkg::DL_W-1:0] diff;
    logic [dest_pkg::DL_W-1:0] span;

    always_comb begin
        diff = i_deadline - i_now;
        // flip the sign bit so unsigned order follows signed distance
        span = {~diff[dest_pkg::DL_W-1], diff[dest_pkg::DL_W-2:0]};
        o_res.due    = (diff == '0) || diff[dest_pkg::DL_W-1];
        o_res.span   = span;
        o_res.better = !i_have_best || (span < i_best_dist);
    end

endmodule

// ===== rtl/core/deadline_event_slot_table.sv =====
`timescale 1ns / 1ps
// channel | port  | direction | payload
// input   | i_in  | sink      | operation, now_ms, delay_ms, slot_id, handler_id, user_tag
// output  | o_out | source    | status, slot, handler, tag, earliest, pending, full, last
//
// Each item scans all slots through one compare unit, each slot compared as its entry
// comes out of the RAM's registered read. A run with expiries walks the expiry mask
// instead of posting a single result: S_SEEK skips clear slots and S_PUT posts each
// expired item. i_in.ready is high only when idle. Reset (synchronous, active low)
// frees every slot. A stalled output holds its item and blocks the next post; the
// block goes idle once the last result is in the register.
module deadline_event_slot_table #(
    parameter int SLOT_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dest_in_if.sink           i_in,
    dest_out_if.source        o_out
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    dest_pkg::t_state           r_state;
    logic [1:0]                 r_op;
    logic [31:0]                r_now;
    logic [31:0]                r_new_dl;
    logic [7:0]                 r_id;
    logic [7:0]                 r_handler;
    logic [15:0]                r_tag;
    logic [SLOT_COUNT-1:0]      r_used;
    logic [SLOT_COUNT-1:0]      r_mask;
    logic [IDX_W-1:0]           r_addr;
    logic                       r_issue;
    logic                       r_pvld;
    logic [IDX_W-1:0]           r_pidx;
    logic                       r_found;
    logic [IDX_W-1:0]           r_slot;
    logic [dest_pkg::CNT_W-1:0] r_exp_cnt;
    logic [dest_pkg::CNT_W-1:0] r_left;
    logic [31:0]                r_best;
    logic [31:0]                r_best_dist;
    logic                       r_pend;
    logic                       r_full;
    dest_pkg::t_out_item        r_out;
    logic                       r_ovld;

    logic                           accept;
    logic                           out_free;
    logic                           post;
    logic                           used_k;
    logic                           take;
    logic                           expire;
    logic                           cand;
    logic [31:0]                    cand_dl;
    logic                           scan_end;
    logic [dest_pkg::CNT_W-1:0]     n_exp_cnt;
    logic                           ram_we;
    logic                           ram_re;
    logic [IDX_W-1:0]               ram_raddr;
    logic [dest_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [dest_pkg::ENTRY_W-1:0]   ram_rdata;
    dest_pkg::t_cmp_res             cmp;
    dest_pkg::t_out_item            one_item;
    logic [31:0]                    earliest;

    assign i_in.ready = (r_state == dest_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovld || o_out.ready;
    assign o_out.valid = r_ovld;
    assign o_out.item  = r_out;

    // a result goes into the output register this cycle
    assign post = out_free && ((r_state == dest_pkg::S_ONE) || (r_state == dest_pkg::S_PUT));

    // per-slot decision during the scan
    always_comb begin
        used_k  = r_used[r_pidx];
        take    = (r_op == dest_pkg::OP_SCHEDULE) && !used_k && !r_found;
        cand_dl = take ? r_new_dl : ram_rdata[dest_pkg::ENTRY_W-1 -: dest_pkg::DL_W];
        expire  = (r_op == dest_pkg::OP_RUN) && used_k && cmp.due
                  && (r_exp_cnt < dest_pkg::CNT_W'(dest_pkg::MAX_RESULTS));
        cand    = take || (used_k && !expire);
        n_exp_cnt = r_exp_cnt + dest_pkg::CNT_W'(expire);
        scan_end  = (r_state == dest_pkg::S_SCAN) && r_pvld && (r_pidx == LAST_IDX);
    end

    dest_unit u_unit (
        .i_deadline  (cand_dl),
        .i_now       (r_now),
        .i_best_dist (r_best_dist),
        .i_have_best (r_pend),
        .o_res       (cmp)
    );

    assign ram_we    = (r_state == dest_pkg::S_SCAN) && r_pvld && take;
    assign ram_wdata = {r_new_dl, r_handler, r_tag};
    assign ram_re    = ((r_state == dest_pkg::S_SCAN) && r_issue)
                       || ((r_state == dest_pkg::S_SEEK) && r_mask[r_addr]);
    assign ram_raddr = r_addr;

    dest_ram #(
        .WIDTH (dest_pkg::ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pidx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign earliest = r_pend ? r_best : '0;

    // single-result items
    always_comb begin
        one_item = '0;
        one_item.earliest_deadline = earliest;
        one_item.any_pending       = r_pend;
        one_item.table_full        = r_full;
        one_item.last              = 1'b1;
        case (r_op)
            dest_pkg::OP_SCHEDULE: begin
                if (r_found) begin
                    one_item.status   = dest_pkg::ST_SCHEDULED;
                    one_item.out_slot = 8'(r_slot);
                end else begin
                    one_item.status   = dest_pkg::ST_FULL;
                end
            end
            dest_pkg::OP_CANCEL: begin
                one_item.out_slot = r_id;
                one_item.status   = (r_id < 8'(SLOT_COUNT)) ? dest_pkg::ST_CANCELLED
                                                            : dest_pkg::ST_BAD_ID;
            end
            dest_pkg::OP_RUN: one_item.status = dest_pkg::ST_NONE;
            default:          one_item.status = dest_pkg::ST_BAD_ID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dest_pkg::S_IDLE;
            r_used  <= '0;
            r_ovld  <= 1'b0;
            r_issue <= 1'b0;
            r_pvld  <= 1'b0;
        end else begin
            if (post) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                dest_pkg::S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_in.item.operation;
                        r_now     <= i_in.item.now_ms;
                        r_new_dl  <= i_in.item.now_ms + {1'b0, i_in.item.delay_ms};
                        r_id      <= i_in.item.slot_id;
                        r_handler <= i_in.item.handler_id;
                        r_tag     <= i_in.item.user_tag;
                        r_mask    <= '0;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_pvld    <= 1'b0;
                        r_found   <= 1'b0;
                        r_exp_cnt <= '0;
                        r_pend    <= 1'b0;
                        r_full    <= 1'b1;
                        if ((i_in.item.operation == dest_pkg::OP_CANCEL)
                            && (i_in.item.slot_id < 8'(SLOT_COUNT))) begin
                            r_used[i_in.item.slot_id[IDX_W-1:0]] <= 1'b0;
                        end
                        r_state <= dest_pkg::S_SCAN;
                    end
                end
                dest_pkg::S_SCAN: begin
                    if (r_issue) begin
                        r_addr <= r_addr + IDX_W'(1);
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_pvld <= r_issue;
                    r_pidx <= r_addr;
                    if (r_pvld) begin
                        if (take) begin
                            r_used[r_pidx] <= 1'b1;
                            r_found        <= 1'b1;
                            r_slot         <= r_pidx;
                        end
                        if (expire) begin
                            r_used[r_pidx] <= 1'b0;
                            r_mask[r_pidx] <= 1'b1;
                        end
                        r_exp_cnt <= n_exp_cnt;
                        if (cand) begin
                            r_pend <= 1'b1;
                            if (cmp.better) begin
                                r_best      <= cand_dl;
                                r_best_dist <= cmp.span;
                            end
                        end else begin
                            r_full <= 1'b0;
                        end
                    end
                    if (scan_end) begin
                        r_addr <= '0;
                        r_left <= n_exp_cnt;
                        r_state <= (n_exp_cnt != '0) ? dest_pkg::S_SEEK : dest_pkg::S_ONE;
                    end
                end
                dest_pkg::S_ONE: begin
                    if (out_free) begin
                        r_out   <= one_item;
                        r_state <= dest_pkg::S_IDLE;
                    end
                end
                dest_pkg::S_SEEK: begin
                    if (r_mask[r_addr]) begin
                        r_state <= dest_pkg::S_PUT;
                    end else begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                end
                dest_pkg::S_PUT: begin
                    if (out_free) begin
                        r_out.status            <= dest_pkg::ST_EXPIRED;
                        r_out.out_slot          <= 8'(r_addr);
                        r_out.out_handler       <= ram_rdata[dest_pkg::TAG_W +: dest_pkg::HDL_W];
                        r_out.out_tag           <= ram_rdata[dest_pkg::TAG_W-1:0];
                        r_out.earliest_deadline <= earliest;
                        r_out.any_pending       <= r_pend;
                        r_out.table_full        <= r_full;
                        r_out.last              <= (r_left == dest_pkg::CNT_W'(1));
                        r_left <= r_left - dest_pkg::CNT_W'(1);
                        r_addr <= r_addr + IDX_W'(1);
                        r_state <= (r_left == dest_pkg::CNT_W'(1)) ? dest_pkg::S_IDLE
                                                                   : dest_pkg::S_SEEK;
                    end
                end
                default: r_state <= dest_pkg::S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/dest_checker.sv =====
`timescale 1ns / 1ps
`include "deadline_event_slot_table_defines.svh"
module dest_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dest_pkg::t_out_item out_item
);

    `DEST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled output item changed")
    `DEST_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in work")
    `DEST_ASSERT_IMP(a_full_status, i_clk, i_rst_n, out_valid && (out_item.status == dest_pkg::ST_FULL), out_item.table_full && out_item.any_pending, "full status without a full table")
    `DEST_ASSERT_IMP(a_empty_summary, i_clk, i_rst_n, out_valid && !out_item.any_pending, (out_item.earliest_deadline == '0) && !out_item.table_full, "empty table with a deadline or full flag")

endmodule

bind deadline_event_slot_table dest_checker u_dest_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_item  (o_out.item)
);
